// ===== hdl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared action codes and result status type for the searchable FIFO queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned DataOutW    = 32;
  localparam int unsigned PosW        = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned OutTdataW   = 48;

  typedef enum logic [ActionWidth-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_SRCH = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    logic found;
    logic underflow;
    logic overflow;
  } res_flags_t;

endpackage

// ===== hdl/fifo_queue_with_search_top.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// FIFO queue of DEPTH values with enqueue, dequeue and first-match search.
//
//   channel  dir  tdata                      tuser
//   s_*      in   [31:0] value               [1:0] action
//   m_*      out  data_out, found, position, -
//                 underflow, overflow,
//                 count, empty_res
//
// A search scans from the head and reads one entry per cycle through the
// single memory read port. One item is in work at a time; the next is
// taken once its result has moved to the output register, which holds it
// while m_tready is low. rst clears pointers, count and the output valid
// flag; entries and the output data are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_top
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] value
  input  logic [1:0]           s_tuser,   // [1:0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata    // [31:0] data_out, [32] found,
                                          // [36:33] position, [37] underflow,
                                          // [38] overflow, [43:39] count,
                                          // [44] empty_res, [47:45] zero
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                  res_valid;
  logic                  res_ready;
  logic [DATA_WIDTH-1:0] res_data;
  logic [AW-1:0]         res_pos;
  logic [CW-1:0]         res_count;
  res_flags_t            res_flags;
  logic [DATA_WIDTH-1:0] in_word;
  action_t               in_action;

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  assign in_word   = DATA_WIDTH'($unsigned(s_tdata[ValueWidth-1:0]));
  assign in_action = action_t'(s_tuser);
  assign res_ready = !m_tvalid || m_tready;

  fqs_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (in_action),
    .in_word     (in_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .res_pos     (res_pos),
    .res_count   (res_count),
    .res_flags   (res_flags),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000,
                  (res_count == '0),
                  CountW'(res_count),
                  res_flags.overflow,
                  res_flags.underflow,
                  PosW'(res_pos),
                  res_flags.found,
                  DataOutW'(res_data)};
    end
  end

endmodule

// ===== hdl/fqs_ram.sv =====
// ----------------------------------------------------------------------------
// fqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fqs_core.sv =====
// ----------------------------------------------------------------------------
// fqs_core
// Ring pointers, element count and the request sequencer that drives the
// entry memory: enqueue writes, dequeue reads, search reads one entry a cycle.
// ----------------------------------------------------------------------------
module fqs_core
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  action_t                    in_action,
  input  logic [DATA_WIDTH-1:0]      in_word,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [DATA_WIDTH-1:0]      res_data,
  output logic [$clog2(DEPTH)-1:0]   res_pos,
  output logic [$clog2(DEPTH+1)-1:0] res_count,
  output res_flags_t                 res_flags,
  output logic                       mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
  output logic [DATA_WIDTH-1:0]      mem_wr_data,
  output logic                       mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]      mem_rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         head;
  logic [AW-1:0]         tail;
  logic [CW-1:0]         count;
  logic [AW-1:0]         scan_idx;
  logic [AW-1:0]         scan_k;
  logic [DATA_WIDTH-1:0] key;

  logic in_fire;
  logic is_full;
  logic is_empty;
  logic scan_hit;
  logic scan_last;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    nxt = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    return nxt;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign scan_hit  = (mem_rd_data == key);
  assign scan_last = ((CW'(scan_k) + CW'(1)) == count);

  assign res_valid = (state == ST_DONE);
  assign res_count = count;

  assign mem_wr_en   = in_fire && (in_action == ACT_ENQ) && !is_full;
  assign mem_wr_addr = tail;
  assign mem_wr_data = in_word;
  assign mem_rd_addr = (state == ST_IDLE) ? head : scan_idx;
  assign mem_rd_en   = (in_fire && !is_empty &&
                        ((in_action == ACT_DEQ) || (in_action == ACT_SRCH))) ||
                       ((state == ST_SCAN) && !scan_hit && !scan_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_data  <= '0;
            res_pos   <= '0;
            res_flags <= '0;
            case (in_action)
              ACT_ENQ: begin
                if (is_full) begin
                  res_flags.overflow <= 1'b1;
                end else begin
                  tail  <= ring_next(tail);
                  count <= count + CW'(1);
                end
                state <= ST_DONE;
              end
              ACT_DEQ: begin
                if (is_empty) begin
                  res_flags.underflow <= 1'b1;
                  state               <= ST_DONE;
                end else begin
                  state <= ST_RD_WAIT;
                end
              end
              ACT_SRCH: begin
                key      <= in_word;
                scan_idx <= ring_next(head);
                scan_k   <= '0;
                state    <= is_empty ? ST_DONE : ST_SCAN;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_data <= mem_rd_data;
          head     <= ring_next(head);
          count    <= count - CW'(1);
          state    <= ST_DONE;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            res_flags.found <= 1'b1;
            res_pos         <= scan_k;
            state           <= ST_DONE;
          end else if (scan_last) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= ring_next(scan_idx);
            scan_k   <= scan_k + AW'(1);
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/fqs_checker.sv =====
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks for the searchable FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqs_checker
  import fqs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OutTdataW-1:0] m_tdata
);

  logic [1:0] pend;
  logic       s_fire;
  logic       m_fire;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(s_fire) - 2'(m_fire);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("second item taken while one is in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != 2'd0)
    else $error("result without a pending item");

endmodule

bind fifo_queue_with_search_top fqs_checker u_fqs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
